FILE: hdl/trbf_pkg.sv
`timescale 1ns / 1ps

package trbf_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RECLAIM = 2'd2;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_MORE      = 3'd1;
  localparam logic [2:0] ST_NO_UNREAD = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [15:0] sensor_id;
    logic [63:0] sensor_value;
    logic [63:0] time_stamp;
  } rec_t;

endpackage

FILE: hdl/two_reader_broadcast_fifo_top.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   cmd_i reader_i sensor_id_i sensor_value_i time_stamp_i
// output    out_valid_o / out_stall_i status_o out_sensor_id_o out_value_o out_time_stamp_o
//
// Each command is accepted in the idle state, where the record memory is accessed;
// the result follows in the output state; a new command is taken once it has left.
// The record memory has one write port and one registered read port.
// Reset clears all pointers at once; the record memory needs no clearing.
// While the result is stalled, the input stays stalled and the result holds.

module two_reader_broadcast_fifo_top #(
  parameter int unsigned DEPTH = trbf_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic        reader_i,
  input  logic [15:0] sensor_id_i,
  input  logic [63:0] sensor_value_i,
  input  logic [63:0] time_stamp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] out_sensor_id_o,
  output logic [63:0] out_value_o,
  output logic [63:0] out_time_stamp_o
);
  import trbf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  rec_t          wdata_w, rdata_w;
  logic          we_w, re_w, deliver_w;
  logic [AW-1:0] waddr_w, raddr_w;

  assign wdata_w.sensor_id    = sensor_id_i;
  assign wdata_w.sensor_value = sensor_value_i;
  assign wdata_w.time_stamp   = time_stamp_i;

  trbf_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .reader_i   (reader_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .deliver_o  (deliver_w),
    .mem_we_o   (we_w),
    .mem_waddr_o(waddr_w),
    .mem_re_o   (re_w),
    .mem_raddr_o(raddr_w)
  );

  trbf_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we_w),
    .waddr_i(waddr_w),
    .wdata_i(wdata_w),
    .re_i   (re_w),
    .raddr_i(raddr_w),
    .rdata_o(rdata_w)
  );

  assign out_sensor_id_o  = deliver_w ? rdata_w.sensor_id    : '0;
  assign out_value_o      = deliver_w ? rdata_w.sensor_value : '0;
  assign out_time_stamp_o = deliver_w ? rdata_w.time_stamp   : '0;

endmodule

FILE: hdl/trbf_store.sv
`timescale 1ns / 1ps

module trbf_store #(
  parameter int unsigned DEPTH = trbf_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  trbf_pkg::rec_t           wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output trbf_pkg::rec_t           rdata_o
);
  import trbf_pkg::*;

  rec_t mem_q [DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/trbf_ctrl.sv
`timescale 1ns / 1ps

module trbf_ctrl #(
  parameter int unsigned DEPTH = trbf_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic                     reader_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic                     deliver_o,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output logic                     mem_re_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o
);
  import trbf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(2 * DEPTH);
  localparam logic [PW-1:0] DepthP  = PW'(DEPTH);
  localparam logic [PW-1:0] PtrMax  = PW'(2 * DEPTH - 1);
  localparam logic [PW-1:0] PtrModP = PW'(2 * DEPTH);

  localparam logic StIdle = 1'b0;
  localparam logic StOut  = 1'b1;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PtrMax) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dist(input logic [PW-1:0] later,
                                             input logic [PW-1:0] earlier);
    logic [PW-1:0] diff;
    diff = later - earlier;
    return (later < earlier) ? diff + PtrModP : diff;
  endfunction

  function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= DepthP) ? p - DepthP : p;
    return s[AW-1:0];
  endfunction

  logic                 state_q, state_d;
  logic [PW-1:0]        head_q, head_d;
  logic [PW-1:0]        tail_q, tail_d;
  logic [1:0][PW-1:0]   rp_q, rp_d;
  logic [2:0]           status_q, status_d;
  logic                 deliver_q, deliver_d;

  logic [PW-1:0]        lag0_w, lag1_w, fill_w;
  logic [PW-1:0]        rec_head_w, fill_after_w, rp_sel_w, rp_inc_w;
  logic                 full_w, in_acc_w;

  assign lag0_w       = ptr_dist(rp_q[0], head_q);
  assign lag1_w       = ptr_dist(rp_q[1], head_q);
  assign fill_w       = ptr_dist(tail_q, head_q);
  assign rec_head_w   = (lag0_w <= lag1_w) ? rp_q[0] : rp_q[1];
  assign fill_after_w = ptr_dist(tail_q, rec_head_w);
  assign full_w       = fill_after_w >= DepthP;
  assign rp_sel_w     = rp_q[reader_i];
  assign rp_inc_w     = ptr_next(rp_sel_w);

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc_w    = in_valid_i && (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign status_o    = status_q;
  assign deliver_o   = deliver_q;
  assign mem_waddr_o = ptr_slot(tail_q);
  assign mem_raddr_o = ptr_slot(rp_sel_w);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    rp_d      = rp_q;
    status_d  = status_q;
    deliver_d = deliver_q;
    mem_we_o  = 1'b0;
    mem_re_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d   = StOut;
          status_d  = ST_DONE;
          deliver_d = 1'b0;
          unique case (cmd_i)
            CMD_INSERT: begin
              head_d = rec_head_w;
              if (full_w) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o = 1'b1;
                tail_d   = ptr_next(tail_q);
              end
            end
            CMD_READ: begin
              if (head_q == tail_q) begin
                status_d = ST_EMPTY;
              end else if (rp_sel_w == tail_q) begin
                status_d = ST_NO_UNREAD;
              end else begin
                mem_re_o         = 1'b1;
                deliver_d        = 1'b1;
                rp_d[reader_i]   = rp_inc_w;
                status_d         = (rp_inc_w != tail_q) ? ST_MORE : ST_DONE;
              end
            end
            CMD_RECLAIM: begin
              head_d = rec_head_w;
            end
            default: begin
            end
          endcase
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      head_q    <= '0;
      tail_q    <= '0;
      rp_q      <= '0;
      status_q  <= ST_DONE;
      deliver_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      rp_q      <= rp_d;
      status_q  <= status_d;
      deliver_q <= deliver_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_w <= DepthP)
    else $error("ring holds more words than its depth");

  a_reader_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lag0_w <= fill_w) && (lag1_w <= fill_w))
    else $error("reader pointer outside the ring");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc_w && (cmd_i == CMD_INSERT) && full_w |=> $stable(tail_q))
    else $error("word written into a full ring");

  a_deliver_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && deliver_q |-> (status_q == ST_MORE) || (status_q == ST_DONE))
    else $error("delivered word with a failure status");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc_w |=> out_valid_o && !mem_we_o && !mem_re_o)
    else $error("memory access while a result is pending");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import trbf_pkg::*;

  localparam int unsigned RING_DEPTH = DEPTH_DEF;
  localparam int unsigned PTR_W = $clog2(RING_DEPTH) + 1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned STIM_WORDS = 1300;

  typedef struct packed {
    logic [1:0] cmd;
    logic       reader;
    rec_t       rec;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0] status;
    rec_t       rec;
  } result_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = CMD_INSERT;
  logic        reader_i = 1'b0;
  logic [15:0] sensor_id_i = '0;
  logic [63:0] sensor_value_i = '0;
  logic [63:0] time_stamp_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] out_sensor_id_o;
  logic [63:0] out_value_o;
  logic [63:0] out_time_stamp_o;

  two_reader_broadcast_fifo_top #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .cmd_i,
    .reader_i,
    .sensor_id_i,
    .sensor_value_i,
    .time_stamp_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .out_sensor_id_o,
    .out_value_o,
    .out_time_stamp_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  cmd_word_t    pending_words[$];
  result_word_t expected_results[$];
  cmd_word_t    offered_word;
  int unsigned  fail_count = 0;

  // Shadow copy of the record ring.
  rec_t             ring_mem[RING_DEPTH];
  logic [PTR_W-1:0] head_ptr = '0;
  logic [PTR_W-1:0] tail_ptr = '0;
  logic [PTR_W-1:0] read_ptr[2] = '{'0, '0};

  function automatic void reclaim_read_records();
    logic [PTR_W-1:0] dist0;
    logic [PTR_W-1:0] dist1;
    dist0 = read_ptr[0] - head_ptr;
    dist1 = read_ptr[1] - head_ptr;
    head_ptr = (dist0 <= dist1) ? read_ptr[0] : read_ptr[1];
  endfunction

  function automatic result_word_t predict_broadcast_result(cmd_word_t w);
    result_word_t     res;
    logic [PTR_W-1:0] fill;
    res = '0;
    res.status = ST_DONE;
    case (w.cmd)
      CMD_INSERT: begin
        reclaim_read_records();
        fill = tail_ptr - head_ptr;
        if (fill >= PTR_W'(RING_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          ring_mem[tail_ptr[PTR_W-2:0]] = w.rec;
          tail_ptr = tail_ptr + PTR_W'(1);
        end
      end
      CMD_READ: begin
        if (head_ptr == tail_ptr) begin
          res.status = ST_EMPTY;
        end else if (read_ptr[w.reader] == tail_ptr) begin
          res.status = ST_NO_UNREAD;
        end else begin
          res.rec = ring_mem[read_ptr[w.reader][PTR_W-2:0]];
          read_ptr[w.reader] = read_ptr[w.reader] + PTR_W'(1);
          res.status = (read_ptr[w.reader] != tail_ptr) ? ST_MORE : ST_DONE;
        end
      end
      CMD_RECLAIM: begin
        reclaim_read_records();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Sender: bursts of words separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_broadcast_result(offered_word));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          offered_word = pending_words.pop_front();
          cmd_i <= offered_word.cmd;
          reader_i <= offered_word.reader;
          sensor_id_i <= offered_word.rec.sensor_id;
          sensor_value_i <= offered_word.rec.sensor_value;
          time_stamp_i <= offered_word.rec.time_stamp;
          in_valid_i <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                   : $urandom_range(0, 2);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern re-picked at random over the run, plus two long hold-offs.
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: status %0d", status_o);
          fail_count++;
        end else begin
          result_word_t exp_w;
          exp_w = expected_results.pop_front();
          if (status_o !== exp_w.status) begin
            $error("status: expected %0d, actual %0d", exp_w.status, status_o);
            fail_count++;
          end
          if (out_sensor_id_o !== exp_w.rec.sensor_id) begin
            $error("out_sensor_id: expected %h, actual %h", exp_w.rec.sensor_id,
                   out_sensor_id_o);
            fail_count++;
          end
          if (out_value_o !== exp_w.rec.sensor_value) begin
            $error("out_value: expected %h, actual %h", exp_w.rec.sensor_value,
                   out_value_o);
            fail_count++;
          end
          if (out_time_stamp_o !== exp_w.rec.time_stamp) begin
            $error("out_time_stamp: expected %h, actual %h", exp_w.rec.time_stamp,
                   out_time_stamp_o);
            fail_count++;
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 50 == 0) begin
        stall_mode = $urandom_range(0, 3);
      end
      if (rx_cycle == 600 || rx_cycle == 2200) begin
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 7) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= rx_cycle[0];
        endcase
      end
    end
  end

  function automatic logic [63:0] rand_word64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_word(logic [1:0] cmd, logic reader, logic [15:0] id,
                            logic [63:0] value, logic [63:0] stamp);
    cmd_word_t w;
    w.cmd = cmd;
    w.reader = reader;
    w.rec.sensor_id = id;
    w.rec.sensor_value = value;
    w.rec.time_stamp = stamp;
    pending_words.push_back(w);
  endtask

  task automatic queue_random_insert();
    queue_word(CMD_INSERT, 1'($urandom_range(0, 1)), 16'($urandom()), rand_word64(),
               rand_word64());
  endtask

  task automatic queue_read(logic reader);
    queue_word(CMD_READ, reader, 16'($urandom()), rand_word64(), rand_word64());
  endtask

  task automatic build_stimulus();
    int unsigned episode;
    int unsigned n;
    int unsigned pick;
    logic        rd;
    queue_read(1'b0);
    queue_read(1'b1);
    queue_word(CMD_RECLAIM, 1'b0, '0, '0, '0);
    queue_word(CMD_UNUSED, 1'b0, '0, '0, '0);
    queue_word(CMD_INSERT, 1'b0, 16'h0000, 64'h0, 64'h0);
    queue_word(CMD_INSERT, 1'b1, 16'hffff, '1, '1);
    queue_word(CMD_INSERT, 1'b0, 16'h5555, 64'haaaa_aaaa_aaaa_aaaa,
               64'h5555_5555_5555_5555);
    repeat (4) queue_read(1'b0);
    queue_word(CMD_RECLAIM, 1'b1, '1, '1, '1);
    repeat (3) queue_read(1'b1);
    queue_word(CMD_RECLAIM, 1'b0, '0, '0, '0);
    queue_read(1'b0);
    queue_read(1'b1);
    queue_word(CMD_INSERT, 1'b1, 16'haaaa, 64'h5555_5555_5555_5555,
               64'haaaa_aaaa_aaaa_aaaa);
    queue_read(1'b1);
    queue_word(CMD_UNUSED, 1'b1, '1, '1, '1);
    queue_read(1'b0);

    while (pending_words.size() < STIM_WORDS) begin
      episode = $urandom_range(0, 9);
      case (episode)
        0, 1: begin
          n = $urandom_range(20, 70);
          repeat (n) queue_random_insert();
        end
        2, 3: begin
          n = $urandom_range(10, 70);
          rd = 1'($urandom_range(0, 1));
          repeat (n) queue_read(rd);
        end
        4: begin
          n = $urandom_range(10, 80);
          repeat (n) queue_read(1'($urandom_range(0, 1)));
        end
        5: begin
          n = $urandom_range(1, 3);
          repeat (n) queue_word(CMD_RECLAIM, 1'($urandom_range(0, 1)), 16'($urandom()),
                                rand_word64(), rand_word64());
        end
        default: begin
          n = $urandom_range(5, 40);
          repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
              queue_random_insert();
            end else if (pick < 85) begin
              queue_read(1'($urandom_range(0, 1)));
            end else begin
              queue_word((pick < 95) ? CMD_RECLAIM : CMD_UNUSED, 1'($urandom_range(0, 1)),
                         16'($urandom()), rand_word64(), rand_word64());
            end
          end
        end
      endcase
    end
  endtask

  initial begin
    build_stimulus();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
